[rtl/assert_macros.svh]
// Assertion macros used by the controller RTL of the array list block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define ALC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset
`define ALC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/alc_pkg.sv]
// Package for the array list block: widths, codes and shared types
package alc_pkg;

    localparam int CAPACITY_DEF = 128;

    localparam int CMD_W = 3;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int ST_W  = 3;
    localparam int IDX_W = 7;
    localparam int LEN_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // Row-wide operation issued by the controller
    typedef enum logic [1:0] {
        CHAIN_HOLD,
        CHAIN_INSERT,
        CHAIN_DELETE,
        CHAIN_ROTATE
    } t_chain_op;

    // Per-cell load select
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT
    } t_cell_op;

    // Width that holds both a position and a length at a given capacity
    function automatic int cmp_width(input int capacity);
        int cw;
        begin
            cw = $clog2(capacity + 1);
            return (cw > POS_W) ? cw : POS_W;
        end
    endfunction

endpackage

[rtl/alc_cmd_if.sv]
// Command channel interface: valid/ready plus command payload
interface alc_cmd_if import alc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

[rtl/alc_res_if.sv]
// Result channel interface: valid/ready plus result payload
interface alc_res_if import alc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic [IDX_W-1:0]        found_index;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        list_length;

    modport source (output valid, status, found_index, read_value, list_length, input ready);
    modport sink   (input valid, status, found_index, read_value, list_length, output ready);
endinterface

[rtl/array_list_insert_delete_search.sv]
// Top level of the array list: row of entry cells plus controller
//
//  channel  | dir | signals                                   | beat
//  ---------+-----+-------------------------------------------+----------------------
//  i_cmd    | in  | command, position, value                  | valid & ready
//  o_res    | out | status, found_index, read_value, list_len | valid & ready
//
// Clear, insert, delete, bad commands: result registered the next cycle.
// Search and valid read: scan through one full rotation of the
// cell row past the head cell, which returns the list to its original order.
// Reset clears the length, state and result valid; cells hold data from their last write.
// A new command beat is taken while idle if the result register is empty or
// its beat completes in the same cycle.
module array_list_insert_delete_search import alc_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    alc_cmd_if.sink   i_cmd,
    alc_res_if.source o_res
);

    localparam int WW = cmp_width(CAPACITY);

    logic [VAL_W-1:0] w_entry [CAPACITY];
    t_cell_op         w_mode  [CAPACITY];
    t_chain_op        w_op;
    logic [WW-1:0]    w_pos;

    assign w_pos = WW'(i_cmd.position);

    alc_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .i_head  (w_entry[0]),
        .o_op    (w_op)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [WW-1:0] IDX = WW'(i);
        logic [VAL_W-1:0] w_prev, w_next;

        if (i == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[0];
        end else begin : g_mid_next
            assign w_next = w_entry[i+1];
        end

        always_comb begin
            case (w_op)
                CHAIN_INSERT: begin
                    if (IDX > w_pos) begin
                        w_mode[i] = CELL_FROM_PREV;
                    end else if (IDX == w_pos) begin
                        w_mode[i] = CELL_LOAD;
                    end else begin
                        w_mode[i] = CELL_HOLD;
                    end
                end
                CHAIN_DELETE: w_mode[i] = (IDX >= w_pos) ? CELL_FROM_NEXT : CELL_HOLD;
                CHAIN_ROTATE: w_mode[i] = CELL_FROM_NEXT;
                default:      w_mode[i] = CELL_HOLD;
            endcase
        end

        alc_cell u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode[i]),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_load  (i_cmd.value),
            .o_entry (w_entry[i])
        );
    end

endmodule

[rtl/alc_cell.sv]
// One list cell: holds an entry and loads from its neighbors or the input
module alc_cell import alc_pkg::*; (
    input  logic             i_clk,
    input  t_cell_op         i_mode,
    input  logic [VAL_W-1:0] i_prev,
    input  logic [VAL_W-1:0] i_next,
    input  logic [VAL_W-1:0] i_load,
    output logic [VAL_W-1:0] o_entry
);

    logic [VAL_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        case (i_mode)
            CELL_LOAD:      r_entry <= i_load;
            CELL_FROM_PREV: r_entry <= i_prev;
            CELL_FROM_NEXT: r_entry <= i_next;
            default:        r_entry <= r_entry;
        endcase
    end

    assign o_entry = r_entry;

endmodule

[rtl/alc_ctrl.sv]
// Controller: command decode, length, rotate-scan sequencer, result register
`include "assert_macros.svh"

module alc_ctrl import alc_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    alc_cmd_if.sink          i_cmd,
    alc_res_if.source        o_res,
    input  logic [VAL_W-1:0] i_head,
    output t_chain_op        o_op
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(CAPACITY);
    localparam int WW = cmp_width(CAPACITY);
    localparam logic [WW-1:0] CAP_W  = WW'(CAPACITY);
    localparam logic [KW-1:0] LAST_K = KW'(CAPACITY - 1);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count;
    logic             r_ov;

    logic [KW-1:0]    r_k;
    logic [KW-1:0]    r_pos;
    logic [VAL_W-1:0] r_key;
    logic             r_srch;
    logic             r_hit;
    logic [KW-1:0]    r_idx;
    logic [VAL_W-1:0] r_rd;

    t_status          r_status;
    logic [IDX_W-1:0] r_found;
    logic [VAL_W-1:0] r_rdv;
    logic [LEN_W-1:0] r_len;

    logic             w_ready, w_accept;
    t_cmd             w_cmd;
    logic [WW-1:0]    w_count, w_pos;

    t_status          d_status;
    logic             d_scan;
    t_chain_op        d_op;
    logic [CW-1:0]    d_count;

    logic             s_in, s_now, s_last;
    logic             n_hit;
    logic [KW-1:0]    n_idx;
    logic [VAL_W-1:0] n_rd;
    logic [WW-1:0]    n_idx_w, d_count_w, r_count_w;

    logic             w_load_imm, w_load_scan;

    assign w_accept = i_cmd.valid && w_ready;
    assign w_cmd    = t_cmd'(i_cmd.command);
    assign w_count  = WW'(r_count);
    assign w_pos    = WW'(i_cmd.position);

    // Command decode against the current length
    always_comb begin
        d_status = ST_BADPOS;
        d_scan   = 1'b0;
        d_op     = CHAIN_HOLD;
        d_count  = r_count;
        case (w_cmd)
            CMD_CLEAR: begin
                d_status = ST_OK;
                d_count  = '0;
            end
            CMD_INSERT: begin
                if (w_count >= CAP_W) begin
                    d_status = ST_FULL;
                end else if (w_pos > w_count) begin
                    d_status = ST_BADPOS;
                end else begin
                    d_status = ST_OK;
                    d_op     = CHAIN_INSERT;
                    d_count  = CW'(r_count + 1'b1);
                end
            end
            CMD_DELETE: begin
                if (r_count == '0) begin
                    d_status = ST_EMPTY;
                end else if (w_pos >= w_count) begin
                    d_status = ST_BADPOS;
                end else begin
                    d_status = ST_OK;
                    d_op     = CHAIN_DELETE;
                    d_count  = CW'(r_count - 1'b1);
                end
            end
            CMD_SEARCH: begin
                if (r_count == '0) begin
                    d_status = ST_EMPTY;
                end else begin
                    d_status = ST_OK;
                    d_scan   = 1'b1;
                end
            end
            CMD_READ: begin
                if (r_count == '0) begin
                    d_status = ST_EMPTY;
                end else if (w_pos >= w_count) begin
                    d_status = ST_BADPOS;
                end else begin
                    d_status = ST_OK;
                    d_scan   = 1'b1;
                end
            end
            default: begin
                d_status = ST_BADPOS;
            end
        endcase
    end

    // Scan step: head cell holds entry r_k this cycle
    assign s_in   = CW'(r_k) < r_count;
    assign s_now  = r_srch && s_in && !r_hit && (i_head == r_key);
    assign s_last = (r_k == LAST_K);
    assign n_hit  = r_hit || s_now;
    assign n_idx  = s_now ? r_k : r_idx;
    assign n_rd   = (!r_srch && (r_k == r_pos)) ? i_head : r_rd;

    assign n_idx_w   = WW'(n_idx);
    assign d_count_w = WW'(d_count);
    assign r_count_w = WW'(r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept && d_scan) n_state = S_SCAN;
            S_SCAN:  if (s_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_ready     = 1'b0;
        o_op        = CHAIN_HOLD;
        w_load_imm  = 1'b0;
        w_load_scan = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_ready    = !r_ov || o_res.ready;
                w_load_imm = w_accept && !d_scan;
                if (w_accept) o_op = d_op;
            end
            S_SCAN: begin
                o_op        = CHAIN_ROTATE;
                w_load_scan = s_last;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    assign i_cmd.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) r_count <= d_count;
            if (w_load_imm || w_load_scan) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_k    <= '0;
            r_pos  <= w_pos[KW-1:0];
            r_key  <= i_cmd.value;
            r_srch <= (w_cmd == CMD_SEARCH);
            r_hit  <= 1'b0;
            r_idx  <= '0;
            r_rd   <= '0;
        end else if (r_state == S_SCAN) begin
            r_k    <= KW'(r_k + 1'b1);
            r_hit  <= n_hit;
            r_idx  <= n_idx;
            r_rd   <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_imm) begin
            r_status <= d_status;
            r_found  <= '0;
            r_rdv    <= '0;
            r_len    <= d_count_w[LEN_W-1:0];
        end else if (w_load_scan) begin
            if (r_srch) begin
                r_status <= n_hit ? ST_OK : ST_NOTFOUND;
                r_found  <= n_hit ? n_idx_w[IDX_W-1:0] : '0;
                r_rdv    <= '0;
            end else begin
                r_status <= ST_OK;
                r_found  <= '0;
                r_rdv    <= n_rd;
            end
            r_len <= r_count_w[LEN_W-1:0];
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.status      = r_status;
    assign o_res.found_index = r_found;
    assign o_res.read_value  = r_rdv;
    assign o_res.list_length = r_len;

    `ALC_ASSERT_ALWAYS(a_count_cap, (!i_rst_n || (r_count_w <= CAP_W)), "length above capacity")
    `ALC_ASSERT(a_scan_done, ((r_state == S_SCAN) && s_last) |=> (r_ov && (r_state == S_IDLE)), "scan end without result")
    `ALC_ASSERT(a_clear, (w_accept && (w_cmd == CMD_CLEAR)) |=> ((r_count == '0) && r_ov), "clear did not empty list")
    `ALC_ASSERT(a_scan_hold, (r_state == S_SCAN) |-> (!w_accept && $stable(r_count)), "list changed during scan")

endmodule

[tb/array_list_checker.sv]
`timescale 1ns / 1ps
// Checker for the array list: mirrors the list on command beats, compares result beats
module array_list_checker import alc_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    alc_cmd_if   i_cmd,
    alc_res_if   i_res,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_model_len,
    output int   o_n_results,
    output int   o_n_full,
    output int   o_n_hits
);

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic [IDX_W-1:0]        found_index;
        logic signed [VAL_W-1:0] read_value;
        logic [LEN_W-1:0]        list_length;
    } t_reply;

    logic signed [VAL_W-1:0] cells [CAPACITY];
    int                      n_cells;
    t_reply                  awaited [$];
    int                      fails;
    int                      n_results;
    int                      n_full;
    int                      n_hits;

    function automatic t_reply apply_command(input logic [CMD_W-1:0]    cmd,
                                             input logic [POS_W-1:0]    pos,
                                             input logic signed [VAL_W-1:0] val);
        t_reply r;
        int     p;
        r        = '0;
        r.status = ST_BADPOS;
        p        = int'(pos);
        case (cmd)
            CMD_CLEAR: begin
                n_cells  = 0;
                r.status = ST_OK;
            end
            CMD_INSERT: begin
                if (n_cells >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (p > n_cells) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int i = n_cells; i > p; i--) cells[i] = cells[i-1];
                    cells[p] = val;
                    n_cells++;
                    r.status = ST_OK;
                end
            end
            CMD_DELETE: begin
                if (n_cells == 0) begin
                    r.status = ST_EMPTY;
                end else if (p >= n_cells) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int i = p; i < n_cells - 1; i++) cells[i] = cells[i+1];
                    n_cells--;
                    r.status = ST_OK;
                end
            end
            CMD_SEARCH: begin
                if (n_cells == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_NOTFOUND;
                    // scan downward so the lowest match wins
                    for (int i = n_cells - 1; i >= 0; i--) begin
                        if (cells[i] == val) begin
                            r.status      = ST_OK;
                            r.found_index = IDX_W'(i);
                        end
                    end
                end
            end
            CMD_READ: begin
                if (n_cells == 0) begin
                    r.status = ST_EMPTY;
                end else if (p >= n_cells) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.read_value = cells[p];
                    r.status     = ST_OK;
                end
            end
            default: r.status = ST_BADPOS;
        endcase
        r.list_length = LEN_W'(n_cells);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            n_cells = 0;
            awaited.delete();
        end else begin
            // results first: a result beat never belongs to a command taken at the same edge
            if (i_res.valid && i_res.ready) begin
                n_results++;
                if (awaited.size() == 0) begin
                    $error("result beat with no command pending");
                    fails++;
                end else begin
                    want = awaited.pop_front();
                    got  = {i_res.status, i_res.found_index, i_res.read_value,
                            i_res.list_length};
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.found_index !== want.found_index) begin
                        $error("found_index: expected %0d, got %0d",
                               want.found_index, got.found_index);
                        fails++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        fails++;
                    end
                    if (got.list_length !== want.list_length) begin
                        $error("list_length: expected %0d, got %0d",
                               want.list_length, got.list_length);
                        fails++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                want = apply_command(i_cmd.command, i_cmd.position, i_cmd.value);
                if (want.status == ST_FULL) n_full++;
                if (i_cmd.command == CMD_SEARCH && want.status == ST_OK) n_hits++;
                awaited.push_back(want);
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= awaited.size();
        o_model_len   <= n_cells;
        o_n_results   <= n_results;
        o_n_full      <= n_full;
        o_n_hits      <= n_hits;
    end

endmodule

[tb/tb_array_list_insert_delete_search.sv]
`timescale 1ns / 1ps
// Testbench top for the array list: clock, reset, command and result traffic, verdict
module tb_array_list_insert_delete_search;
    import alc_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int LIMIT      = 400000;
    localparam int DRAIN_WAIT = CAPACITY + 20;
    localparam int HOLD_LEN   = 300;
    localparam int HOLD_AT    = 80;

    logic i_clk;
    logic i_rst_n;

    alc_cmd_if cmd_bus ();
    alc_res_if res_bus ();

    int fail_count;
    int outstanding;
    int model_len;
    int n_results;
    int n_full;
    int n_hits;

    int n_sent;
    bit quiet;
    int cycles;

    array_list_insert_delete_search #(.CAPACITY(CAPACITY)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    array_list_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_bus),
        .i_res         (res_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_model_len   (model_len),
        .o_n_results   (n_results),
        .o_n_full      (n_full),
        .o_n_hits      (n_hits)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                             input logic [VAL_W-1:0] v);
        while (!quiet && $urandom_range(99) < 33) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.command  <= c;
        cmd_bus.position <= p;
        cmd_bus.value    <= v;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic pick_item(input int w_ins, input int w_del, input int w_look,
                             input int w_misc,
                             output logic [CMD_W-1:0] c, output logic [POS_W-1:0] p,
                             output logic [VAL_W-1:0] v);
        int roll;
        int top_pos;
        roll = $urandom_range(w_ins + w_del + w_look + w_misc - 1);
        if (roll < w_ins)
            c = CMD_INSERT;
        else if (roll < w_ins + w_del)
            c = CMD_DELETE;
        else if (roll < w_ins + w_del + w_look)
            c = $urandom_range(1) ? CMD_SEARCH : CMD_READ;
        else if ($urandom_range(2) == 0)
            c = CMD_CLEAR;
        else
            c = CMD_W'($urandom_range((1 << CMD_W) - 1, CMD_READ + 1));
        top_pos = (c == CMD_INSERT) ? model_len : model_len - 1;
        if (top_pos < 0) top_pos = 0;
        p = ($urandom_range(99) < 85) ? POS_W'($urandom_range(top_pos)) : POS_W'($urandom);
        // values mostly from a small pool so searches hit and duplicates occur
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            2:       v = VAL_W'(100);
            3:       v = {1'b0, {(VAL_W-1){1'b1}}};
            4:       v = {1'b1, {(VAL_W-1){1'b0}}};
            5, 6:    v = VAL_W'($urandom_range(7));
            default: v = $urandom;
        endcase
    endtask

    initial begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && n_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= quiet || ($urandom_range(99) >= 33);
            end
        end
    end

    initial begin : stimulus
        logic [CMD_W-1:0] c;
        logic [POS_W-1:0] p;
        logic [VAL_W-1:0] v;
        int               guard;
        n_sent = 0;
        quiet  = 1'b0;
        i_rst_n          <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.command  <= CMD_CLEAR;
        cmd_bus.position <= '0;
        cmd_bus.value    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners on an empty list
        send_item(CMD_SEARCH, '0, '0);
        send_item(CMD_DELETE, '0, '0);
        send_item(CMD_READ,   '0, '0);
        send_item(CMD_INSERT, POS_W'(1), '0);
        // build [min, 100, max, -1]
        send_item(CMD_INSERT, '0, {1'b0, {(VAL_W-1){1'b1}}});
        send_item(CMD_INSERT, '0, {1'b1, {(VAL_W-1){1'b0}}});
        send_item(CMD_INSERT, POS_W'(2), '1);
        send_item(CMD_INSERT, POS_W'(1), VAL_W'(100));
        send_item(CMD_INSERT, '1, '0);
        for (int i = 0; i < 4; i++) send_item(CMD_READ, POS_W'(i), '0);
        send_item(CMD_READ, POS_W'(4), '0);
        send_item(CMD_READ, '1, '0);
        send_item(CMD_SEARCH, '0, '1);
        // duplicate key: lowest index must win
        send_item(CMD_INSERT, '0, '1);
        send_item(CMD_SEARCH, '0, '1);
        send_item(CMD_SEARCH, '0, VAL_W'(12345));
        send_item(CMD_DELETE, POS_W'(5), '0);
        send_item(CMD_DELETE, POS_W'(4), '0);
        send_item(CMD_DELETE, '0, '0);
        for (int i = CMD_READ + 1; i < (1 << CMD_W); i++) send_item(CMD_W'(i), '0, '0);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_SEARCH, '0, '0);

        repeat (150) begin
            pick_item(35, 20, 40, 5, c, p, v);
            send_item(c, p, v);
        end

        // fill to capacity with both sides running flat out
        quiet = 1'b1;
        guard = 0;
        while (model_len < CAPACITY && guard < 400) begin
            pick_item(90, 0, 10, 0, c, p, v);
            send_item(c, p, v);
            guard++;
        end
        quiet = 1'b0;

        repeat (30) begin
            pick_item(50, 15, 35, 0, c, p, v);
            send_item(c, p, v);
        end
        repeat (120) begin
            pick_item(10, 55, 35, 2, c, p, v);
            send_item(c, p, v);
        end
        repeat (60) begin
            pick_item(35, 25, 35, 5, c, p, v);
            send_item(c, p, v);
        end
        cmd_bus.valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d command beats and %0d result beats: empty and bad position",
                 n_sent, n_results);
        $display("corners, fill to capacity (%0d full reports), %0d search hits, long hold-off",
                 n_full, n_hits);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
